@@ sv/line_break_opportunity_check_top_defines.svh @@
// ----------------------------------------------------------------------------
// Line break opportunity check - assertion macros
// Concurrent checks on the clk domain, disabled while rst is high.
// Empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LINE_BREAK_OPPORTUNITY_CHECK_TOP_DEFINES_SVH
`define LINE_BREAK_OPPORTUNITY_CHECK_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define LBOC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("line break check: implication failed");
// Next-cycle implication
`define LBOC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("line break check: next-cycle implication failed");
`else
`define LBOC_ASSERT_IMP(lbl, ante, cons)
`define LBOC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ sv/lboc_pkg.sv @@
// ----------------------------------------------------------------------------
// Line break opportunity check - package
// Character classes, kinsoku table and the flag word between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package lboc_pkg;

  localparam logic [15:0] CH_TAB     = 16'h0009;
  localparam logic [15:0] CH_CR      = 16'h000D;
  localparam logic [15:0] CH_SPACE   = 16'h0020;
  localparam logic [15:0] CH_QUOTE   = 16'h0022;
  localparam logic [15:0] CH_HYPHEN  = 16'h002D;
  localparam logic [15:0] CH_IDEO_SP = 16'h3000;

  // Kinsoku class bits
  localparam logic [1:0] KC_NONE = 2'b00;
  localparam logic [1:0] KC_NB   = 2'b01;
  localparam logic [1:0] KC_NE   = 2'b10;
  localparam logic [1:0] KC_BOTH = 2'b11;

  // Classification of one window, registered between stage 2 and stage 3
  typedef struct packed {
    logic off_zero;
    logic off_two;
    logic bp_space;
    logic pv_space;
    logic cu_space;
    logic nx_space;
    logic cu_east_asian;
    logic pv_east_asian;
    logic pv_quote;
    logic cu_quote;
    logic pv_hyphen;
    logic cu_nb;
    logic pv_ne;
    logic nx_nb;
  } lboc_class_t;

  function automatic logic is_space(input logic [15:0] c);
    return (c == CH_TAB) || (c == CH_CR) || (c == CH_SPACE) || (c == CH_IDEO_SP);
  endfunction

  function automatic logic is_east_asian(input logic [15:0] c);
    return c inside {[16'h1100:16'h11FF], [16'h3000:16'hD7AF],
                     [16'hF900:16'hFAFF], [16'hFF00:16'hFFDC]};
  endfunction

  // Exact membership in the kinsoku table
  function automatic logic [1:0] kinsoku_class(input logic [15:0] c);
    logic [1:0] k;
    case (c) inside
      16'h0027, 16'h002F, 16'hFFE0: k = KC_BOTH;
      16'h0024, 16'h0028, 16'h005B, 16'h005C, 16'h007B, 16'h00A3, 16'h00A5,
      16'h00A7, 16'h2018, 16'h201C, 16'h2035, 16'h266F, 16'h3008, 16'h300A,
      16'h300C, 16'h300E, 16'h3010, 16'h3012, 16'h3014, 16'h3016, 16'h301D,
      16'hFE59, 16'hFE5B, 16'hFE5D, 16'hFF04, 16'hFF08, 16'hFF20, 16'hFF3B,
      16'hFF5B, 16'hFFE1, 16'hFFE5, 16'hFFE6: k = KC_NE;
      16'h0021, 16'h0025, 16'h0029, 16'h002E, 16'h003A, 16'h003B, 16'h003F,
      16'h005D, 16'h007D, 16'h00A2, 16'h00A8, 16'h00A9, 16'h00AE, 16'h00B0,
      16'h00B7, 16'h02C7, 16'h02C9, 16'h2013, 16'h2014, 16'h2015, 16'h2016,
      16'h2019, 16'h201D, 16'h2025, 16'h2026, 16'h2027, 16'h2032, 16'h2033,
      16'h2103, 16'h2122, 16'h2236, 16'h2574, 16'h3001, 16'h3002, 16'h3003,
      16'h3005, 16'h3009, 16'h300B, 16'h300D, 16'h300F, 16'h3011, 16'h3015,
      16'h3017, 16'h301E, 16'h301F, 16'h3041, 16'h3043, 16'h3045, 16'h3047,
      16'h3049, 16'h3063, 16'h3083, 16'h3085, 16'h3087, 16'h308E, 16'h3099,
      16'h309A, 16'h309B, 16'h309C, 16'h309D, 16'h309E, 16'h30A1, 16'h30A3,
      16'h30A5, 16'h30A7, 16'h30A9, 16'h30C3, 16'h30E3, 16'h30E5, 16'h30E7,
      16'h30EE, 16'h30F5, 16'h30F6, 16'h30FB, 16'h30FC, 16'h30FD, 16'h30FE,
      16'hFE50, 16'hFE51, 16'hFE52, 16'hFE54, 16'hFE55, 16'hFE56, 16'hFE57,
      16'hFE5A, 16'hFE5C, 16'hFE5E, 16'hFF01, 16'hFF02, 16'hFF05, 16'hFF07,
      16'hFF09, 16'hFF0C, 16'hFF0E, 16'hFF1A, 16'hFF1B, 16'hFF1F, 16'hFF3D,
      16'hFF40, 16'hFF5C, 16'hFF5D, 16'hFF5E: k = KC_NB;
      default: k = KC_NONE;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

@@ sv/line_break_opportunity_check_top.sv @@
// ----------------------------------------------------------------------------
// Line break opportunity check - top level
// Decides per candidate position whether a line may break before cur_char,
// using a four-code-unit window and the saturated line offset (kinsoku rules).
//
//   channel  handshake            payload
//   -------  -------------------  -----------------------------------------
//   in       start & !busy        before_prev_char, prev_char, cur_char,
//                                 next_char, line_offset
//   out      done (one cycle)     can_break
//
// Three register stages: input capture, character classification (table
// lookups and range tests), rule combination. One word per cycle while busy
// is low. busy is rst registered: high while rst is held and in the cycle
// after it is released; rst clears all valid bits.
// The receiver cannot stall, so the pipeline advances on every clock.
// ----------------------------------------------------------------------------
`default_nettype none
`include "line_break_opportunity_check_top_defines.svh"

module line_break_opportunity_check_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] before_prev_char,
  input  wire logic [15:0] prev_char,
  input  wire logic [15:0] cur_char,
  input  wire logic [15:0] next_char,
  input  wire logic [1:0]  line_offset,
  output logic             done,
  output logic             can_break
);
  import lboc_pkg::*;

  logic accept;

  // Stage 1: captured window
  logic        s1_valid;
  logic [15:0] s1_bp;
  logic [15:0] s1_pv;
  logic [15:0] s1_cu;
  logic [15:0] s1_nx;
  logic [1:0]  s1_off;

  // Stage 2: classification flags
  logic        s2_valid;
  lboc_class_t s2_cls;
  lboc_class_t cls_next;

  logic can_break_next;

  assign accept = start && !busy;

  // Hold off words for the first cycle out of reset
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // Stage 1: capture the window of an accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_bp  <= before_prev_char;
      s1_pv  <= prev_char;
      s1_cu  <= cur_char;
      s1_nx  <= next_char;
      s1_off <= line_offset;
    end
  end

  // Stage 2: classify every character of the window in parallel.
  // Offset code three falls in with two (bit 1 set).
  always_comb begin
    logic [1:0] cu_k;
    logic [1:0] pv_k;
    logic [1:0] nx_k;
    cu_k = kinsoku_class(s1_cu);
    pv_k = kinsoku_class(s1_pv);
    nx_k = kinsoku_class(s1_nx);
    cls_next.off_zero      = (s1_off == 2'd0);
    cls_next.off_two       = s1_off[1];
    cls_next.bp_space      = is_space(s1_bp);
    cls_next.pv_space      = is_space(s1_pv);
    cls_next.cu_space      = is_space(s1_cu);
    cls_next.nx_space      = is_space(s1_nx);
    cls_next.cu_east_asian = is_east_asian(s1_cu);
    cls_next.pv_east_asian = is_east_asian(s1_pv);
    cls_next.pv_quote      = (s1_pv == CH_QUOTE);
    cls_next.cu_quote      = (s1_cu == CH_QUOTE);
    cls_next.pv_hyphen     = (s1_pv == CH_HYPHEN);
    cls_next.cu_nb         = |(cu_k & KC_NB);
    cls_next.pv_ne         = |(pv_k & KC_NE);
    cls_next.nx_nb         = |(nx_k & KC_NB);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_cls <= cls_next;
    end
  end

  // Stage 3: apply the rules in priority order
  always_comb begin
    if (s2_cls.off_zero) begin
      // never break at the start of a line
      can_break_next = 1'b0;
    end else if (s2_cls.cu_space && s2_cls.nx_nb) begin
      // space followed by a non-beginning character
      can_break_next = 1'b0;
    end else if (s2_cls.off_two && s2_cls.bp_space && s2_cls.pv_quote &&
                 !s2_cls.cu_space) begin
      // open quote left dangling at the end of the line
      can_break_next = 1'b0;
    end else if (!s2_cls.pv_space && s2_cls.cu_quote && s2_cls.nx_space) begin
      // closing quote pushed to the next line
      can_break_next = 1'b0;
    end else begin
      can_break_next = (s2_cls.cu_space || s2_cls.cu_east_asian ||
                        s2_cls.pv_east_asian || s2_cls.pv_hyphen) &&
                       !s2_cls.cu_nb && !s2_cls.pv_ne;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      can_break <= can_break_next;
    end
  end

  // Every accepted word yields exactly one result
  `LBOC_ASSERT_IMP(a_word_yields_result, accept, ##3 done)
  `LBOC_ASSERT_IMP(a_result_has_word, done, $past(accept, 3))
  // A result never allows a break at line start
  `LBOC_ASSERT_IMP(a_no_break_line_start, done && can_break, $past(line_offset, 3) != 2'd0)
  // A break before a non-beginning character is never reported
  `LBOC_ASSERT_NXT(a_no_break_nb, s2_valid && s2_cls.cu_nb, !can_break)

endmodule

`default_nettype wire

@@ tb/line_break_opportunity_check_checker.sv @@
// ----------------------------------------------------------------------------
// Line break opportunity check - result checker
// Watches the command and result channels of the block. Predicts can_break for
// every accepted word and compares it, in order, with each strobed result.
// ----------------------------------------------------------------------------
module line_break_opportunity_check_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [15:0] before_prev_char,
  input  logic [15:0] prev_char,
  input  logic [15:0] cur_char,
  input  logic [15:0] next_char,
  input  logic [1:0]  line_offset,
  input  logic        done,
  input  logic        can_break,
  output int          fail_count,
  output int          pending
);
  import lboc_pkg::*;

  localparam int PRINT_CAP = 40;

  typedef struct {
    logic [15:0] bp;
    logic [15:0] pv;
    logic [15:0] cu;
    logic [15:0] nx;
    logic [1:0]  off;
    logic        brk;
  } break_case_t;

  break_case_t expected_breaks [$];
  int mismatches = 0;

  function automatic logic blank(input logic [15:0] c);
    return c == CH_TAB || c == CH_CR || c == CH_SPACE || c == CH_IDEO_SP;
  endfunction

  function automatic logic cjk(input logic [15:0] c);
    return (c >= 16'h1100 && c <= 16'h11FF) || (c >= 16'h3000 && c <= 16'hD7AF) ||
           (c >= 16'hF900 && c <= 16'hFAFF) || (c >= 16'hFF00 && c <= 16'hFFDC);
  endfunction

  // Characters that may not begin a line
  function automatic logic starts_forbidden(input logic [15:0] c);
    case (c)
      16'h0021, 16'h0025, 16'h0027, 16'h0029, 16'h002E, 16'h002F, 16'h003A, 16'h003B,
      16'h003F, 16'h005D, 16'h007D, 16'h00A2, 16'h00A8, 16'h00A9, 16'h00AE, 16'h00B0,
      16'h00B7, 16'h02C7, 16'h02C9, 16'h2013, 16'h2014, 16'h2015, 16'h2016, 16'h2019,
      16'h201D, 16'h2025, 16'h2026, 16'h2027, 16'h2032, 16'h2033, 16'h2103, 16'h2122,
      16'h2236, 16'h2574, 16'h3001, 16'h3002, 16'h3003, 16'h3005, 16'h3009, 16'h300B,
      16'h300D, 16'h300F, 16'h3011, 16'h3015, 16'h3017, 16'h301E, 16'h301F, 16'h3041,
      16'h3043, 16'h3045, 16'h3047, 16'h3049, 16'h3063, 16'h3083, 16'h3085, 16'h3087,
      16'h308E, 16'h3099, 16'h309A, 16'h309B, 16'h309C, 16'h309D, 16'h309E, 16'h30A1,
      16'h30A3, 16'h30A5, 16'h30A7, 16'h30A9, 16'h30C3, 16'h30E3, 16'h30E5, 16'h30E7,
      16'h30EE, 16'h30F5, 16'h30F6, 16'h30FB, 16'h30FC, 16'h30FD, 16'h30FE, 16'hFE50,
      16'hFE51, 16'hFE52, 16'hFE54, 16'hFE55, 16'hFE56, 16'hFE57, 16'hFE5A, 16'hFE5C,
      16'hFE5E, 16'hFF01, 16'hFF02, 16'hFF05, 16'hFF07, 16'hFF09, 16'hFF0C, 16'hFF0E,
      16'hFF1A, 16'hFF1B, 16'hFF1F, 16'hFF3D, 16'hFF40, 16'hFF5C, 16'hFF5D, 16'hFF5E,
      16'hFFE0: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Characters that may not end a line
  function automatic logic ends_forbidden(input logic [15:0] c);
    case (c)
      16'h0024, 16'h0027, 16'h0028, 16'h002F, 16'h005B, 16'h005C, 16'h007B, 16'h00A3,
      16'h00A5, 16'h00A7, 16'h2018, 16'h201C, 16'h2035, 16'h266F, 16'h3008, 16'h300A,
      16'h300C, 16'h300E, 16'h3010, 16'h3012, 16'h3014, 16'h3016, 16'h301D, 16'hFE59,
      16'hFE5B, 16'hFE5D, 16'hFF04, 16'hFF08, 16'hFF20, 16'hFF3B, 16'hFF5B, 16'hFFE0,
      16'hFFE1, 16'hFFE5, 16'hFFE6: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic break_allowed(input logic [15:0] bp, input logic [15:0] pv,
                                         input logic [15:0] cu, input logic [15:0] nx,
                                         input logic [1:0] off);
    if (off == 2'd0)
      return 1'b0;
    if (blank(cu) && starts_forbidden(nx))
      return 1'b0;
    // offset code three counts as two or more characters into the line
    if (off >= 2'd2 && blank(bp) && pv == CH_QUOTE && !blank(cu))
      return 1'b0;
    if (!blank(pv) && cu == CH_QUOTE && blank(nx))
      return 1'b0;
    return (blank(cu) || cjk(cu) || cjk(pv) || pv == CH_HYPHEN) &&
           !starts_forbidden(cu) && !ends_forbidden(pv);
  endfunction

  task automatic note_mismatch(input string what);
    if (mismatches < PRINT_CAP)
      $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    break_case_t head;
    break_case_t word;
    if (!rst) begin
      // retire the oldest expectation on each strobe
      if (done === 1'b1) begin
        if (expected_breaks.size() == 0) begin
          note_mismatch("result strobed with nothing expected");
        end else begin
          head = expected_breaks.pop_front();
          if (can_break !== head.brk)
            note_mismatch($sformatf(
              "bp=%04h pv=%04h cu=%04h nx=%04h off=%0d: can_break %b, expected %b",
              head.bp, head.pv, head.cu, head.nx, head.off, can_break, head.brk));
        end
      end else if (done !== 1'b0) begin
        note_mismatch("done is unknown");
      end
      if (start === 1'b1 && busy === 1'b0) begin
        word.bp  = before_prev_char;
        word.pv  = prev_char;
        word.cu  = cur_char;
        word.nx  = next_char;
        word.off = line_offset;
        word.brk = break_allowed(word.bp, word.pv, word.cu, word.nx, word.off);
        expected_breaks.push_back(word);
      end
    end
    fail_count <= mismatches;
    pending    <= expected_breaks.size();
  end

endmodule

@@ tb/tb_line_break_opportunity_check_top.sv @@
// ----------------------------------------------------------------------------
// Line break opportunity check - testbench top
// Drives candidate windows into the block: a directed set on the rule corners,
// then random words, mostly a sliding text stream with line restarts, under
// three sender idle profiles. The checker beside the block predicts and
// compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_line_break_opportunity_check_top;
  import lboc_pkg::*;

  localparam int CLK_HALF        = 2;
  localparam int RESET_CYCLES    = 11;
  localparam int WORDS_PER_PHASE = 567;
  // three pipeline stages; leave a few spare edges after the last strobe
  localparam int DRAIN_CYCLES    = 8;
  localparam int CYCLE_LIMIT     = 200000;

  logic        clk              = 1'b0;
  logic        rst              = 1'b1;
  logic        start            = 1'b0;
  logic [15:0] before_prev_char = 16'h0000;
  logic [15:0] prev_char        = 16'h0000;
  logic [15:0] cur_char         = 16'h0000;
  logic [15:0] next_char        = 16'h0000;
  logic [1:0]  line_offset      = 2'd0;
  logic        busy;
  logic        done;
  logic        can_break;

  int fail_count;
  int pending;
  int cycles = 0;
  int sender_idle_pct = 0;

  // Sliding text window for the stream part of the random stimulus
  logic [15:0] text_bp  = CH_SPACE;
  logic [15:0] text_pv  = CH_SPACE;
  logic [15:0] text_cu  = CH_SPACE;
  logic [15:0] text_nx  = CH_SPACE;
  logic [1:0]  text_off = 2'd0;

  always #CLK_HALF clk = ~clk;

  line_break_opportunity_check_top DUT (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .before_prev_char (before_prev_char),
    .prev_char        (prev_char),
    .cur_char         (cur_char),
    .next_char        (next_char),
    .line_offset      (line_offset),
    .done             (done),
    .can_break        (can_break)
  );

  line_break_opportunity_check_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .before_prev_char (before_prev_char),
    .prev_char        (prev_char),
    .cur_char         (cur_char),
    .next_char        (next_char),
    .line_offset      (line_offset),
    .done             (done),
    .can_break        (can_break),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // Watchdog: end the run if the block stops answering
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_line_break_opportunity_check_top NOT OK");
      $finish;
    end
  end

  // Pick a code unit, weighted toward the characters the rules care about
  function automatic logic [15:0] pick_char();
    int unsigned sel;
    logic [15:0] c;
    sel = $urandom_range(99);
    if (sel < 15) begin
      case ($urandom_range(3))
        0:       c = CH_TAB;
        1:       c = CH_CR;
        2:       c = CH_SPACE;
        default: c = CH_IDEO_SP;
      endcase
    end else if (sel < 22) begin
      c = CH_QUOTE;
    end else if (sel < 28) begin
      c = CH_HYPHEN;
    end else if (sel < 58) begin
      // windows dense in kinsoku table members, plus plain ASCII text
      case ($urandom_range(12))
        0:       c = 16'($urandom_range(16'h007F, 16'h0020));
        1:       c = 16'($urandom_range(16'h00BF, 16'h00A0));
        2:       c = 16'($urandom_range(16'h02CF, 16'h02C0));
        3:       c = 16'($urandom_range(16'h2040, 16'h2010));
        4:       c = 16'($urandom_range(16'h2125, 16'h2100));
        5:       c = 16'($urandom_range(16'h2240, 16'h2230));
        6:       c = 16'($urandom_range(16'h2578, 16'h2570));
        7:       c = 16'($urandom_range(16'h2670, 16'h2668));
        8:       c = 16'($urandom_range(16'h3020, 16'h3000));
        9:       c = 16'($urandom_range(16'h30FF, 16'h3040));
        10:      c = 16'($urandom_range(16'hFE5F, 16'hFE50));
        11:      c = 16'($urandom_range(16'hFF60, 16'hFF00));
        default: c = 16'($urandom_range(16'hFFE7, 16'hFFDA));
      endcase
    end else if (sel < 68) begin
      // edges of the East Asian ranges
      case ($urandom_range(15))
        0:       c = 16'h10FF;
        1:       c = 16'h1100;
        2:       c = 16'h11FF;
        3:       c = 16'h1200;
        4:       c = 16'h2FFF;
        5:       c = 16'h3000;
        6:       c = 16'hD7AF;
        7:       c = 16'hD7B0;
        8:       c = 16'hF8FF;
        9:       c = 16'hF900;
        10:      c = 16'hFAFF;
        11:      c = 16'hFB00;
        12:      c = 16'hFEFF;
        13:      c = 16'hFF00;
        14:      c = 16'hFFDC;
        default: c = 16'hFFDD;
      endcase
    end else if (sel < 73) begin
      c = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    end else begin
      c = 16'($urandom_range(16'hFFFF));
    end
    return c;
  endfunction

  // Present one word and hold it until the block takes it
  task automatic send_word(input logic [15:0] bp, input logic [15:0] pv,
                           input logic [15:0] cu, input logic [15:0] nx,
                           input logic [1:0] off);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start            <= 1'b1;
    before_prev_char <= bp;
    prev_char        <= pv;
    cur_char         <= cu;
    next_char        <= nx;
    line_offset      <= off;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_random_word();
    if ($urandom_range(9) < 7) begin
      // advance the text by one code unit; restart the line now and then
      if ($urandom_range(11) == 0)
        text_off = 2'd0;
      else if (text_off < 2'd2)
        text_off++;
      text_bp = text_pv;
      text_pv = text_cu;
      text_cu = text_nx;
      text_nx = ($urandom_range(19) == 0) ? 16'h0000 : pick_char();
      send_word(text_bp, text_pv, text_cu, text_nx, text_off);
    end else begin
      // loose window, any offset code including the out-of-range one
      send_word(pick_char(), pick_char(), pick_char(), pick_char(),
                2'($urandom_range(3)));
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed corners, back to back
    sender_idle_pct = 0;
    send_word(16'h0041, 16'h4E00, 16'h4E01, 16'h0041, 2'd0);   // line start
    send_word(16'h0000, 16'h0000, 16'h0000, 16'h0000, 2'd0);
    send_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3);
    send_word(16'h0041, 16'h4E00, CH_SPACE, 16'h3001, 2'd1);   // space before closer
    send_word(16'h0041, 16'h0041, CH_IDEO_SP, 16'h0021, 2'd2);
    send_word(CH_SPACE, CH_QUOTE, 16'h4E00, 16'h0041, 2'd2);   // dangling open quote
    send_word(CH_TAB, CH_QUOTE, 16'h4E00, 16'h0041, 2'd1);     // same, too close to start
    send_word(CH_CR, CH_QUOTE, 16'h4E00, 16'h0041, 2'd3);      // offset code three
    send_word(CH_SPACE, CH_QUOTE, CH_SPACE, 16'h0041, 2'd2);
    send_word(16'h0041, 16'h4E00, CH_QUOTE, CH_SPACE, 2'd2);   // closing quote
    send_word(16'h0041, CH_SPACE, CH_QUOTE, CH_SPACE, 2'd2);
    send_word(16'h0041, CH_HYPHEN, 16'h0062, 16'h0063, 2'd2);  // hyphen
    send_word(16'h0041, 16'h0061, 16'h0062, 16'h0063, 2'd2);   // plain Latin
    send_word(16'h0041, 16'h4E00, 16'h3002, 16'h0041, 2'd2);   // non-beginning
    send_word(16'h0041, 16'h300C, 16'h4E00, 16'h0041, 2'd2);   // non-ending
    send_word(16'h0041, 16'h0027, 16'h4E00, 16'h0041, 2'd2);   // both classes
    send_word(16'h0041, 16'h4E00, 16'h3013, 16'h0000, 2'd1);   // absent, end of text
    send_word(16'h0041, 16'h0061, 16'h1100, 16'h0000, 2'd2);
    send_word(16'h0041, 16'h0061, 16'h10FF, 16'h0000, 2'd2);
    send_word(16'h0041, 16'h11FF, 16'h0062, 16'h0000, 2'd2);
    send_word(16'h0041, 16'hD7B0, 16'hD7AF, 16'h0000, 2'd2);
    send_word(16'h0041, 16'hFFDD, 16'hFFDC, 16'h0000, 2'd2);
    send_word(16'h0041, 16'hF8FF, 16'hF900, 16'h0000, 2'd2);
    send_word(16'h0041, 16'hFB00, 16'hFAFF, 16'h0000, 2'd2);

    // Random words under three sender profiles
    sender_idle_pct = 19;
    repeat (WORDS_PER_PHASE) send_random_word();
    sender_idle_pct = 45;
    repeat (WORDS_PER_PHASE) send_random_word();
    sender_idle_pct = 0;
    repeat (WORDS_PER_PHASE) send_random_word();
    start <= 1'b0;

    // Drain: wait for every expected result, then a few spare edges
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0)
      $display("tb_line_break_opportunity_check_top OK");
    else
      $display("tb_line_break_opportunity_check_top NOT OK");
    $finish;
  end

endmodule
